>>> design/imgf_pkg.sv
// shared types and constants for the interval merge gap finder
package imgf_pkg;
    localparam int MaxItemsDefault = 64;
    localparam int Margin = 4;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 17;

    typedef enum logic [2:0] {
        CFG_HORIZONTAL = 3'd0,
        CFG_BAR_LEFT   = 3'd1,
        CFG_BAR_TOP    = 3'd2,
        CFG_BAR_RIGHT  = 3'd3,
        CFG_BAR_BOTTOM = 3'd4,
        CFG_RO_WIDTH   = 3'd5,
        CFG_RO_HEIGHT  = 3'd6,
        CFG_PREF_OFF   = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] ClassOther = 2'd0;
    localparam logic [1:0] ClassInteractive = 2'd1;
    localparam logic [1:0] ClassContainer = 2'd2;
    localparam logic [1:0] ClassSpare = 2'd3;

    typedef struct packed {
        logic               horizontal;
        logic signed [15:0] bar_left;
        logic signed [15:0] bar_top;
        logic signed [15:0] bar_right;
        logic signed [15:0] bar_bottom;
        logic [14:0]        ro_width;
        logic [14:0]        ro_height;
        logic [16:0]        pref_off;
    } t_cfg;

    // queue entry between front and back
    typedef struct packed {
        logic               keep;
        logic               last;
        logic signed [16:0] s;
        logic signed [16:0] e;
    } t_span_cmd;
endpackage

>>> design/imgf_front.sv
// front end: filters items and turns them into axis spans
module imgf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imgf_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_l,
    input  logic signed [15:0]    i_t,
    input  logic signed [15:0]    i_r,
    input  logic signed [15:0]    i_b,
    input  logic [1:0]            i_cls,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output imgf_pkg::t_span_cmd   o_cmd
);
    logic                r_v;
    imgf_pkg::t_span_cmd r_cmd;
    imgf_pkg::t_span_cmd n_cmd;
    logic                cls_ok, nonempty, overlap, wide;
    logic signed [17:0]  bar_len, item_len;
    logic signed [21:0]  item10, bar9;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_cmd   = r_cmd;

    always_comb begin
        cls_ok   = (i_cls == imgf_pkg::ClassInteractive) || (i_cls == imgf_pkg::ClassContainer);
        nonempty = (i_r > i_l) && (i_b > i_t);
        overlap  = (i_r > i_cfg.bar_left) && (i_l < i_cfg.bar_right)
                && (i_b > i_cfg.bar_top) && (i_t < i_cfg.bar_bottom);
        bar_len  = i_cfg.horizontal ? 18'(i_cfg.bar_right) - 18'(i_cfg.bar_left)
                                    : 18'(i_cfg.bar_bottom) - 18'(i_cfg.bar_top);
        item_len = i_cfg.horizontal ? 18'(i_r) - 18'(i_l) : 18'(i_b) - 18'(i_t);
        item10   = 22'(item_len) * 22'sd10;
        bar9     = 22'(bar_len) * 22'sd9;
        wide     = (i_cls == imgf_pkg::ClassContainer) && (item10 >= bar9);
        n_cmd.keep = cls_ok && nonempty && overlap && !wide;
        n_cmd.last = i_last;
        n_cmd.s    = (i_cfg.horizontal ? 17'(i_l) : 17'(i_t)) - 17'(imgf_pkg::Margin);
        n_cmd.e    = (i_cfg.horizontal ? 17'(i_r) : 17'(i_b)) + 17'(imgf_pkg::Margin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule

>>> design/imgf_queue.sv
// short queue between front and back
module imgf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  imgf_pkg::t_span_cmd i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output imgf_pkg::t_span_cmd o_cmd
);
    imgf_pkg::t_span_cmd r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_ready = r_cnt != 3'd4;
    assign o_valid = r_cnt != 3'd0;
    assign o_cmd   = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, wr} - {2'd0, rd};
        end
        if (wr) r_mem[r_wp] <= i_cmd;
    end
endmodule

>>> design/imgf_back.sv
// back end: stores spans, sorts, merges and searches the gaps
module imgf_back #(
    parameter int MAX_ITEMS = imgf_pkg::MaxItemsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imgf_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  imgf_pkg::t_span_cmd i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_found,
    output logic signed [16:0]  o_l,
    output logic signed [16:0]  o_t,
    output logic signed [16:0]  o_r,
    output logic signed [16:0]  o_b
);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_SORT_RD, S_SORT_PRV, S_SORT_CMP, S_SORT_WR, S_PREF, S_ROUND,
        S_MERGE_RD, S_MERGE, S_GAP, S_DIST, S_FINAL, S_OUT
    } t_state;

    t_state r_st;
    logic signed [16:0] r_ms [MAX_ITEMS];
    logic signed [16:0] r_me [MAX_ITEMS];
    logic [CW-1:0] r_cnt, r_i, r_j;
    logic signed [16:0] r_key_s, r_key_e, r_rd_s, r_rd_e;
    logic signed [17:0] r_a0, r_a1, r_req;
    logic signed [40:0] r_pref;
    logic signed [22:0] r_rounded;
    logic signed [17:0] r_ms_cur, r_me_cur, r_cursor;
    logic               r_have;
    logic signed [17:0] r_gs, r_ge, r_cand;
    logic               r_found;
    logic signed [22:0] r_best;
    logic [41:0]        r_bestd;
    logic               r_ok;
    logic signed [16:0] r_ol, r_ot, r_or, r_ob;

    logic signed [17:0] a0, a1, req, len;
    logic signed [17:0] cs, ce;
    logic signed [41:0] x, d;
    logic [41:0]        ax, ad;
    logic signed [22:0] cand;
    logic signed [17:0] cross_a, cross_b;
    logic signed [15:0] cw;
    logic signed [18:0] cdiff;
    logic signed [17:0] chalf;
    logic [AW-1:0]      jm1;

    assign o_ready = (r_st == S_LOAD);
    assign o_valid = (r_st == S_OUT);
    assign o_found = r_ok;
    assign o_l = r_ol;
    assign o_t = r_ot;
    assign o_r = r_or;
    assign o_b = r_ob;

    always_comb begin
        a0  = i_cfg.horizontal ? 18'(i_cfg.bar_left) : 18'(i_cfg.bar_top);
        a1  = i_cfg.horizontal ? 18'(i_cfg.bar_right) : 18'(i_cfg.bar_bottom);
        req = i_cfg.horizontal ? 18'($signed({1'b0, i_cfg.ro_width}))
                               : 18'($signed({1'b0, i_cfg.ro_height}));
        len = a1 - a0;
        jm1 = AW'(r_j - 1'b1);
        cs = (18'(r_rd_s) < r_a0) ? r_a0 : ((18'(r_rd_s) > r_a1) ? r_a1 : 18'(r_rd_s));
        ce = (18'(r_rd_e) < r_a0) ? r_a0 : ((18'(r_rd_e) > r_a1) ? r_a1 : 18'(r_rd_e));
        x  = 42'(r_pref) - 42'(r_req) * 42'sd32768;
        ax = x[41] ? 42'(-x) : 42'(x);
        cand = (r_rounded < 23'(r_gs)) ? 23'(r_gs)
             : ((r_rounded > 23'(r_ge - r_req)) ? 23'(r_ge - r_req) : r_rounded);
        d  = 42'(r_cand) * 42'sd65536 + 42'(r_req) * 42'sd32768 - 42'(r_pref);
        ad = d[41] ? 42'(-d) : 42'(d);
        cross_a = i_cfg.horizontal ? 18'(i_cfg.bar_top) : 18'(i_cfg.bar_left);
        cross_b = i_cfg.horizontal ? 18'(i_cfg.bar_bottom) : 18'(i_cfg.bar_right);
        cw = i_cfg.horizontal ? $signed({1'b0, i_cfg.ro_height})
                              : $signed({1'b0, i_cfg.ro_width});
        cdiff = 19'(cross_b) - 19'(cross_a) - 19'(cw);
        chalf = 18'((cdiff + ((cdiff[18] && cdiff[0]) ? 19'sd1 : 19'sd0)) >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_LOAD;
            r_cnt <= '0;
        end else begin
            unique case (r_st)
                S_LOAD: if (i_valid) begin
                    if (i_cmd.keep && r_cnt < CW'(MAX_ITEMS)) begin
                        r_ms[r_cnt[AW-1:0]] <= i_cmd.s;
                        r_me[r_cnt[AW-1:0]] <= i_cmd.e;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (i_cmd.last) begin
                        r_a0 <= a0;
                        r_a1 <= a1;
                        r_req <= req;
                        r_i <= CW'(1);
                        r_ok <= 1'b0;
                        r_found <= 1'b0;
                        if ((r_cnt == '0 && !(i_cmd.keep)) || len < req) r_st <= S_FINAL;
                        else r_st <= S_SORT_RD;
                    end
                end
                S_SORT_RD: begin
                    if (r_i >= r_cnt) begin
                        r_st <= S_PREF;
                    end else begin
                        r_key_s <= r_ms[r_i[AW-1:0]];
                        r_key_e <= r_me[r_i[AW-1:0]];
                        r_j <= r_i;
                        r_st <= S_SORT_PRV;
                    end
                end
                S_SORT_PRV: begin
                    if (r_j == '0) begin
                        r_st <= S_SORT_WR;
                    end else begin
                        r_rd_s <= r_ms[jm1];
                        r_rd_e <= r_me[jm1];
                        r_st <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP: begin
                    if (r_rd_s > r_key_s) begin
                        r_ms[r_j[AW-1:0]] <= r_rd_s;
                        r_me[r_j[AW-1:0]] <= r_rd_e;
                        r_j <= r_j - 1'b1;
                        r_st <= S_SORT_PRV;
                    end else begin
                        r_st <= S_SORT_WR;
                    end
                end
                S_SORT_WR: begin
                    r_ms[r_j[AW-1:0]] <= r_key_s;
                    r_me[r_j[AW-1:0]] <= r_key_e;
                    r_i <= r_i + 1'b1;
                    r_st <= S_SORT_RD;
                end
                S_PREF: begin
                    r_pref <= 41'(r_a0) * 41'sd65536 + 41'((i_cfg.pref_off > 17'd65536)
                        ? 18'sd65536 : $signed({1'b0, i_cfg.pref_off})) * 41'(r_a1 - r_a0);
                    r_st <= S_ROUND;
                end
                S_ROUND: begin
                    r_rounded <= x[41] ? -23'((ax + 42'd32768) >> 16)
                                       : 23'((ax + 42'd32768) >> 16);
                    r_cursor <= r_a0;
                    r_have <= 1'b0;
                    r_i <= '0;
                    r_st <= S_MERGE_RD;
                end
                S_MERGE_RD: begin
                    if (r_i >= r_cnt) begin
                        // flush pending merged span then the tail gap
                        if (r_have) begin
                            r_gs <= r_cursor;
                            r_ge <= r_ms_cur;
                            if (r_me_cur > r_cursor) r_cursor <= r_me_cur;
                            r_have <= 1'b0;
                            r_st <= S_GAP;
                        end else begin
                            r_gs <= r_cursor;
                            r_ge <= r_a1;
                            r_i <= r_cnt + 1'b1;
                            r_st <= S_GAP;
                        end
                    end else begin
                        r_rd_s <= r_ms[r_i[AW-1:0]];
                        r_rd_e <= r_me[r_i[AW-1:0]];
                        r_st <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    r_i <= r_i + 1'b1;
                    if (ce > cs && r_have && cs > r_me_cur) begin
                        // a new merged span closes the gap before it
                        r_gs <= r_cursor;
                        r_ge <= r_ms_cur;
                        r_ms_cur <= cs;
                        r_me_cur <= ce;
                        if (r_me_cur > r_cursor) r_cursor <= r_me_cur;
                        r_st <= S_GAP;
                    end else begin
                        if (ce > cs) begin
                            if (r_have) begin
                                if (ce > r_me_cur) r_me_cur <= ce;
                            end else begin
                                r_have <= 1'b1;
                                r_ms_cur <= cs;
                                r_me_cur <= ce;
                            end
                        end
                        r_st <= S_MERGE_RD;
                    end
                end
                S_GAP: begin
                    r_cand <= 18'(cand);
                    r_st <= S_DIST;
                end
                S_DIST: begin
                    if ((r_ge - r_gs >= r_req) && (!r_found || ad < r_bestd)) begin
                        r_found <= 1'b1;
                        r_best <= 23'(r_cand);
                        r_bestd <= ad;
                    end
                    if (r_i > r_cnt) r_st <= S_FINAL;
                    else r_st <= S_MERGE_RD;
                end
                S_FINAL: begin
                    r_cnt <= '0;
                    if (r_found) begin
                        r_ok <= 1'b1;
                        if (i_cfg.horizontal) begin
                            r_ol <= 17'(r_best);
                            r_or <= 17'(r_best) + 17'(i_cfg.ro_width);
                            r_ot <= 17'(cross_a) + 17'(chalf);
                            r_ob <= 17'(cross_a) + 17'(chalf) + 17'(i_cfg.ro_height);
                        end else begin
                            r_ot <= 17'(r_best);
                            r_ob <= 17'(r_best) + 17'(i_cfg.ro_height);
                            r_ol <= 17'(cross_a) + 17'(chalf);
                            r_or <= 17'(cross_a) + 17'(chalf) + 17'(i_cfg.ro_width);
                        end
                    end else begin
                        r_ok <= 1'b0;
                        r_ol <= '0;
                        r_ot <= '0;
                        r_or <= '0;
                        r_ob <= '0;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (i_ready) r_st <= S_LOAD;
                default: r_st <= S_LOAD;
            endcase
        end
    end
endmodule

>>> design/interval_merge_gap_finder.sv
// top level of the interval merge gap finder
// Items load at one per cycle unless the input stalls, through a filter stage and a
// four-entry queue; the item marked last starts the closing pass over the stored
// spans: an insertion sort of up to MAX_ITEMS spans, then a merge step over the
// sorted spans and a gap step for each gap, then one result transfer. During
// that closing pass the filter stage and the queue still take up to five more
// items, after which the input stalls until the result transfer has been taken.
module interval_merge_gap_finder #(
    parameter int MAX_ITEMS = imgf_pkg::MaxItemsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // item_left, item_top, item_right, item_bottom, item_class, zero pad
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found, place_left, place_top, place_right, place_bottom, zero pad
    output logic [71:0] m_axis_tdata
);
    imgf_pkg::t_cfg      r_cfg;
    imgf_pkg::t_span_cmd f_cmd, q_cmd;
    logic f_v, f_r, q_v, q_r;
    logic o_found;
    logic signed [16:0] pl, pt, pr, pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{horizontal: 1'b1, bar_left: '0, bar_top: '0, bar_right: '0,
                       bar_bottom: '0, ro_width: '0, ro_height: '0,
                       pref_off: 17'd32768};
        end else if (i_cfg_we) begin
            unique case (imgf_pkg::t_cfg_idx'(i_cfg_idx))
                imgf_pkg::CFG_HORIZONTAL: r_cfg.horizontal <= i_cfg_data[0];
                imgf_pkg::CFG_BAR_LEFT:   r_cfg.bar_left <= i_cfg_data[15:0];
                imgf_pkg::CFG_BAR_TOP:    r_cfg.bar_top <= i_cfg_data[15:0];
                imgf_pkg::CFG_BAR_RIGHT:  r_cfg.bar_right <= i_cfg_data[15:0];
                imgf_pkg::CFG_BAR_BOTTOM: r_cfg.bar_bottom <= i_cfg_data[15:0];
                imgf_pkg::CFG_RO_WIDTH:   r_cfg.ro_width <= i_cfg_data[14:0];
                imgf_pkg::CFG_RO_HEIGHT:  r_cfg.ro_height <= i_cfg_data[14:0];
                imgf_pkg::CFG_PREF_OFF:   r_cfg.pref_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imgf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_l(s_axis_tdata[15:0]), .i_t(s_axis_tdata[31:16]),
        .i_r(s_axis_tdata[47:32]), .i_b(s_axis_tdata[63:48]),
        .i_cls(s_axis_tdata[65:64]), .i_last(s_axis_tlast),
        .o_valid(f_v), .i_ready(f_r), .o_cmd(f_cmd)
    );

    imgf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_v), .o_ready(f_r), .i_cmd(f_cmd),
        .o_valid(q_v), .i_ready(q_r), .o_cmd(q_cmd)
    );

    imgf_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(q_v), .o_ready(q_r), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_found(o_found), .o_l(pl), .o_t(pt), .o_r(pr), .o_b(pb)
    );

    assign m_axis_tdata = {3'd0, pb, pr, pt, pl, o_found};
endmodule

>>> sim/tb_interval_merge_gap_finder.sv
// testbench for the interval merge gap finder: self-checking, random item sets with stalls
module tb_interval_merge_gap_finder;

    typedef struct {
        bit              found;
        logic [16:0]     pl, pt, pr, pb;
    } t_placement;

    class placement_board;
        bit              horiz;
        longint          bl, bt, br, bb, rw, rh, poff;
        longint          ss[$], se[$];
        t_placement      pending[$];
        int              errors;

        function new();
            horiz = 1; bl = 0; bt = 0; br = 0; bb = 0; rw = 0; rh = 0; poff = 32768;
            errors = 0;
        endfunction

        function void write_reg(imgf_pkg::t_cfg_idx idx, logic [16:0] v);
            case (idx)
                imgf_pkg::CFG_HORIZONTAL: horiz = v[0];
                imgf_pkg::CFG_BAR_LEFT:   bl = longint'($signed(v[15:0]));
                imgf_pkg::CFG_BAR_TOP:    bt = longint'($signed(v[15:0]));
                imgf_pkg::CFG_BAR_RIGHT:  br = longint'($signed(v[15:0]));
                imgf_pkg::CFG_BAR_BOTTOM: bb = longint'($signed(v[15:0]));
                imgf_pkg::CFG_RO_WIDTH:   rw = v[14:0];
                imgf_pkg::CFG_RO_HEIGHT:  rh = v[14:0];
                imgf_pkg::CFG_PREF_OFF:   poff = v;
                default: ;
            endcase
        endfunction

        function longint clampv(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function bit find_start(output longint best);
            longint a0, a1, req, off, pref, x, rnd, cur, bd, gs, ge, cand, d, s, e, t1, t2;
            longint ms[$], me[$];
            bit fnd;
            fnd = 0; bd = 0; best = 0;
            a0 = horiz ? bl : bt;
            a1 = horiz ? br : bb;
            req = horiz ? rw : rh;
            off = poff > 65536 ? 65536 : poff;
            if (ss.size() == 0 || a1 - a0 < req) return 0;
            for (int i = 1; i < ss.size(); i++) begin
                for (int j = i; j > 0 && ss[j-1] > ss[j]; j--) begin
                    t1 = ss[j]; ss[j] = ss[j-1]; ss[j-1] = t1;
                    t2 = se[j]; se[j] = se[j-1]; se[j-1] = t2;
                end
            end
            foreach (ss[i]) begin
                s = clampv(ss[i], a0, a1);
                e = clampv(se[i], a0, a1);
                if (e > s) begin
                    if (ms.size() > 0 && s <= me[$]) begin
                        if (e > me[$]) me[$] = e;
                    end else begin
                        ms = {ms, s};
                        me = {me, e};
                    end
                end
            end
            pref = a0 * 65536 + off * (a1 - a0);
            x = pref - req * 32768;
            rnd = (x >= 0) ? ((x + 32768) >>> 16) : -((-x + 32768) >>> 16);
            cur = a0;
            for (int i = 0; i <= ms.size(); i++) begin
                gs = cur;
                ge = (i < ms.size()) ? ms[i] : a1;
                if (ge - gs >= req) begin
                    cand = clampv(rnd, gs, ge - req);
                    d = cand * 65536 + req * 32768 - pref;
                    if (d < 0) d = -d;
                    if (!fnd || d < bd) begin
                        fnd = 1; best = cand; bd = d;
                    end
                end
                if (i < ms.size() && me[i] > cur) cur = me[i];
            end
            return fnd;
        endfunction

        function void note_item(longint l, longint t, longint r, longint b, int cls, bit lst);
            longint blen, ilen, st, pl, pt, pr, pb;
            t_placement res;
            if ((cls == int'(imgf_pkg::ClassInteractive) ||
                 cls == int'(imgf_pkg::ClassContainer)) && r > l && b > t &&
                r > bl && l < br && b > bt && t < bb) begin
                blen = horiz ? br - bl : bb - bt;
                ilen = horiz ? r - l : b - t;
                if (!(cls == int'(imgf_pkg::ClassContainer) && ilen * 10 >= blen * 9) &&
                    ss.size() < imgf_pkg::MaxItemsDefault) begin
                    ss = {ss, (horiz ? l : t) - imgf_pkg::Margin};
                    se = {se, (horiz ? r : b) + imgf_pkg::Margin};
                end
            end
            if (!lst) return;
            res = '{default: 0};
            if (find_start(st)) begin
                if (horiz) begin
                    pl = st; pr = st + rw;
                    pt = bt + (bb - bt - rh) / 2; pb = pt + rh;
                end else begin
                    pt = st; pb = st + rh;
                    pl = bl + (br - bl - rw) / 2; pr = pl + rw;
                end
                res.found = 1;
                res.pl = pl[16:0]; res.pt = pt[16:0]; res.pr = pr[16:0]; res.pb = pb[16:0];
            end
            ss.delete(); se.delete();
            pending = {pending, res};
        endfunction

        function void check_result(logic [71:0] d);
            t_placement x;
            if (pending.size() == 0) begin
                $error("result transfer with none expected: %h", d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[0] !== x.found) begin
                $error("found: expected %0d got %0d", x.found, d[0]); errors++;
            end
            if (d[17:1] !== x.pl) begin
                $error("place_left: expected %h got %h", x.pl, d[17:1]); errors++;
            end
            if (d[34:18] !== x.pt) begin
                $error("place_top: expected %h got %h", x.pt, d[34:18]); errors++;
            end
            if (d[51:35] !== x.pr) begin
                $error("place_right: expected %h got %h", x.pr, d[51:35]); errors++;
            end
            if (d[68:52] !== x.pb) begin
                $error("place_bottom: expected %h got %h", x.pb, d[68:52]); errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
    // item_left, item_top, item_right, item_bottom, item_class, zero pad
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    // found, place_left, place_top, place_right, place_bottom, zero pad
    logic [71:0] m_axis_tdata;

    placement_board board;
    int          cycles;
    int          stall_mode;
    int          burst_left;

    interval_merge_gap_finder dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= cycles[3];
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 3));
    end

    task automatic write_reg(imgf_pkg::t_cfg_idx idx, logic [16:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        board.write_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                             logic [15:0] b, logic [1:0] cls, bit lst);
        int gap;
        if (burst_left == 0) begin
            gap = int'($urandom_range(0, 6));
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 12));
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, cls, b, r, t, l};
        s_axis_tlast <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item($signed(l), $signed(t), $signed(r), $signed(b), cls, lst);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // writes the bar, its orientation, the box size and the preferred offset
    task automatic set_bar(bit h, int l, int t, int r, int b, int w, int hh, int off);
        write_reg(imgf_pkg::CFG_HORIZONTAL, 17'(h));
        write_reg(imgf_pkg::CFG_BAR_LEFT, l[16:0]);
        write_reg(imgf_pkg::CFG_BAR_TOP, t[16:0]);
        write_reg(imgf_pkg::CFG_BAR_RIGHT, r[16:0]);
        write_reg(imgf_pkg::CFG_BAR_BOTTOM, b[16:0]);
        write_reg(imgf_pkg::CFG_RO_WIDTH, w[16:0]);
        write_reg(imgf_pkg::CFG_RO_HEIGHT, hh[16:0]);
        write_reg(imgf_pkg::CFG_PREF_OFF, off[16:0]);
    endtask

    task automatic random_item(bit lst);
        int a0, a1, c0, c1, s, len;
        logic [1:0] cls;
        a0 = int'(board.horiz ? board.bl : board.bt);
        a1 = int'(board.horiz ? board.br : board.bb);
        c0 = int'(board.horiz ? board.bt : board.bl);
        c1 = int'(board.horiz ? board.bb : board.br);
        if ($urandom_range(0, 9) == 0) begin
            send_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      2'($urandom_range(0, 3)), lst);
            return;
        end
        s = a0 - 20 + int'($urandom_range(0, (a1 > a0 ? a1 - a0 : 0) + 40));
        len = int'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3000)
                                             : $urandom_range(1, 60));
        cls = ($urandom_range(0, 5) == 0) ? imgf_pkg::ClassContainer
                                          : imgf_pkg::ClassInteractive;
        if (board.horiz)
            send_item(16'(s), 16'(c0 - 2), 16'(s + len), 16'(c1 + 2), cls, lst);
        else
            send_item(16'(c0 - 2), 16'(s), 16'(c1 + 2), 16'(s + len), cls, lst);
    endtask

    initial begin
        int n, total, l, t, w, hh;
        board = new();
        cycles = 0; stall_mode = 0; burst_left = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = imgf_pkg::CFG_HORIZONTAL; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0; m_axis_tready = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: empty bar, no spans, then one item
        send_item(0, 0, 0, 0, imgf_pkg::ClassInteractive, 1);
        send_item(0, 0, 10, 10, imgf_pkg::ClassInteractive, 1);
        drain();
        set_bar(1, 0, 0, 1000, 40, 100, 20, 32768);
        send_item(100, 0, 200, 40, imgf_pkg::ClassOther, 0);
        send_item(300, 5, 300, 30, imgf_pkg::ClassInteractive, 0);
        send_item(2000, 0, 2100, 40, imgf_pkg::ClassInteractive, 0);
        send_item(16'(-50), 0, 950, 40, imgf_pkg::ClassContainer, 0);
        send_item(0, 0, 899, 40, imgf_pkg::ClassContainer, 0);
        send_item(450, 0, 560, 40, imgf_pkg::ClassInteractive, 0);
        send_item(400, 0, 420, 40, imgf_pkg::ClassSpare, 1);
        send_item(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, imgf_pkg::ClassInteractive, 1);
        drain();
        set_bar(0, -32768, -32768, 32767, 32767, 32767, 32767, 131071);
        send_item(16'h8000, 0, 16'(-32000), 100, imgf_pkg::ClassInteractive, 1);
        drain();
        set_bar(1, 32767, -32768, -32768, 32767, 0, 0, 0);
        send_item(0, 0, 10, 10, imgf_pkg::ClassInteractive, 1);
        drain();
        set_bar(0, 0, 0, 50, 1000, 10, 900, 65536);
        for (int i = 0; i < 70; i++)
            send_item(0, 16'(i * 3), 50, 16'(i * 3 + 2), imgf_pkg::ClassInteractive, i == 69);
        drain();

        total = 0;
        while (total < 1600) begin
            l = $urandom_range(0, 1) ? int'($signed(16'($urandom))) / 2
                                     : int'($urandom_range(0, 500));
            t = int'($urandom_range(0, 400));
            w = int'($urandom_range(0, 15) == 0 ? $urandom_range(0, 32767)
                                                : $urandom_range(0, 200));
            hh = int'($urandom_range(0, 60));
            set_bar($urandom_range(0, 1), l, t, l + int'($urandom_range(0, 1500)),
                    t + int'($urandom_range(0, 1500)), w, hh, int'($urandom_range(0, 70000)));
            if ($urandom_range(0, 9) == 0)
                write_reg(imgf_pkg::t_cfg_idx'($urandom_range(0, 7)), 17'($urandom));
            for (int k = 0; k < 4; k++) begin
                n = int'($urandom_range(0, 9) == 0 ? $urandom_range(60, 72)
                                                   : $urandom_range(1, 12));
                for (int i = 0; i < n; i++) random_item(i == n - 1);
                total += n;
            end
            drain();
        end

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> sim.f
design/imgf_pkg.sv
design/imgf_front.sv
design/imgf_queue.sv
design/imgf_back.sv
design/interval_merge_gap_finder.sv
sim/tb_interval_merge_gap_finder.sv
